// ===== sv/polyline_uniform_resampler_defines.svh =====
// ----------------------------------------------------------------------------
// Polyline resampler assertion macros
// Shared property forms for the checker of the resampler ports.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_UNIFORM_RESAMPLER_DEFINES_SVH
`define POLYLINE_UNIFORM_RESAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define PUR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define PUR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pur_pkg.sv =====
// ----------------------------------------------------------------------------
// Polyline resampler package
// Widths, defaults and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package pur_pkg;

  localparam int COORD_W       = 24;
  localparam int SPACE_W       = 23;
  localparam int MAX_OUT_DEF   = 64;
  localparam int FRAC_BITS_DEF = 8;
  localparam int LEN_W         = 25;
  localparam int DIV_QW        = 25;
  localparam int DIV_DW        = 26;
  localparam int SQ_OW         = 25;

  localparam logic [SPACE_W-1:0] SPACE_RESET = 23'd256;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EMITV,
    S_DIFF,
    S_SQ1,
    S_SQ2,
    S_SQ3,
    S_SQRT,
    S_SEG,
    S_CDIV,
    S_CAND,
    S_MX,
    S_NX,
    S_DX,
    S_MY,
    S_NY,
    S_DY,
    S_CHK,
    S_FINAL,
    S_DONE,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

endpackage

`default_nettype wire

// ===== sv/pur_div.sv =====
// ----------------------------------------------------------------------------
// Polyline resampler serial divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pur_div #(
  parameter int QW = pur_pkg::DIV_QW,
  parameter int DW = pur_pkg::DIV_DW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [QW+DW-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic [QW-1:0]    quotient,
  output logic [DW-1:0]    remainder,
  output logic             done
);

  localparam int CNTW = $clog2(QW);

  logic [DW-1:0]   rem;
  logic [QW-1:0]   sh;
  logic [DW-1:0]   dv;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            take;

  assign trial = {rem, sh[QW-1]};
  assign diff  = trial - {1'b0, dv};
  assign take  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend[QW+DW-1:QW];
        sh   <= dividend[QW-1:0];
        dv   <= divisor;
        cnt  <= CNTW'(QW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= take ? diff[DW-1:0] : trial[DW-1:0];
        sh  <= {sh[QW-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = sh;
  assign remainder = rem;

endmodule

`default_nettype wire

// ===== sv/pur_sqrt.sv =====
// ----------------------------------------------------------------------------
// Polyline resampler serial square root
// Floor square root, one root bit and two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pur_sqrt #(
  parameter int OW = pur_pkg::SQ_OW
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*OW-1:0] radicand,
  output logic [OW-1:0]   root,
  output logic            done
);

  localparam int RW   = 2 * OW;
  localparam int MW   = OW + 2;
  localparam int TW   = OW + 4;
  localparam int CNTW = $clog2(OW);

  logic [RW-1:0]   sh;
  logic [MW-1:0]   rem;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [TW-1:0]   trial;
  logic [TW-1:0]   test;
  logic            take;

  assign trial = {rem, sh[RW-1:RW-2]};
  assign test  = TW'({root, 2'b01});
  assign take  = trial >= test;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh   <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= CNTW'(OW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        sh   <= {sh[RW-3:0], 2'b00};
        rem  <= take ? MW'(trial - test) : trial[MW-1:0];
        root <= {root[OW-2:0], take};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/pur_rbuf.sv =====
// ----------------------------------------------------------------------------
// Polyline resampler result buffer
// Holds the points of one vertex until the step is complete.
// ----------------------------------------------------------------------------
`default_nettype none

module pur_rbuf #(
  parameter int DEPTH = pur_pkg::MAX_OUT_DEF,
  parameter int AW    = $clog2(pur_pkg::MAX_OUT_DEF),
  parameter int DW    = 2 * pur_pkg::COORD_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/polyline_uniform_resampler.sv =====
// ----------------------------------------------------------------------------
// Polyline uniform resampler
// Emits points spaced evenly by arc length along an incoming polyline.
// ----------------------------------------------------------------------------
// Vertices arrive on the s_axis channel, one per word; tuser marks the first
// vertex and tlast the final vertex of a polyline. Points leave on m_axis,
// with tlast on the last point caused by a vertex and tuser carrying the
// polyline end and clipped flags. The spacing register is written through
// cfg_wr_en and cfg_wr_data; the user must write it only while the block is
// idle, since the block itself does not enforce that.
// One vertex is worked on at a time. A first or pass-through vertex is
// written straight to the result buffer. A segment is measured by the
// squares, the serial square root and the remainder division, and the
// division is skipped when no sample falls on it. Each candidate sample
// takes the two serial divisions of the interpolation. Every point is then
// read out of the result buffer. A new vertex is taken once the last point
// of the previous one sits in the output register.
// Reset restores spacing 256, clears the stored vertex and point to the
// origin and empties the output. A stalled receiver holds the output word
// and halts readout; no point is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_uniform_resampler #(
  parameter int MAX_OUT   = pur_pkg::MAX_OUT_DEF,
  parameter int FRAC_BITS = pur_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [pur_pkg::SPACE_W-1:0]    cfg_wr_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [2*pur_pkg::COORD_W-1:0]  s_axis_tdata,  // vertex_x, vertex_y
  input  logic [0:0]                     s_axis_tuser,  // is_first
  input  logic                           s_axis_tlast,  // is_final
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [2*pur_pkg::COORD_W-1:0]  m_axis_tdata,  // point_x, point_y
  output logic [1:0]                     m_axis_tuser,  // polyline end, clipped
  output logic                           m_axis_tlast   // run_end
);

  import pur_pkg::*;

  localparam int AW      = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int CW      = $clog2(MAX_OUT + 1);
  localparam int DUP_TOL = (1 << FRAC_BITS) / 1000;
  localparam int CARRY_W = 24;
  localparam int PW      = LEN_W + 1;
  localparam int PRODW   = COORD_W + LEN_W;
  localparam int NW      = DIV_QW + DIV_DW;

  localparam logic signed [COORD_W:0] TOL_S     = (COORD_W+1)'(DUP_TOL);
  localparam logic [CW-1:0]           SLOTS_ALL = CW'(MAX_OUT);
  localparam logic [CW-1:0]           SLOTS_FIN = CW'(MAX_OUT - 1);

  state_t state, state_next;

  logic [SPACE_W-1:0] sp;
  logic [COORD_W-1:0] prev_x, prev_y, em_x, em_y;
  logic [COORD_W-1:0] vx, vy, nx, ny;
  logic [CARRY_W-1:0] carried;
  logic [1:0]         em_cnt;
  logic               fin_r;
  logic               sgn_x, sgn_y;
  logic [COORD_W-1:0] mag_x, mag_y;
  logic [PRODW-1:0]   prod, acc;
  logic [LEN_W-1:0]   len;
  logic [PW-1:0]      p;
  logic [CW-1:0]      n, rd_idx;
  logic               clip_r;

  logic [COORD_W-1:0]  mul_a;
  logic [LEN_W-1:0]    mul_b;
  logic [COORD_W:0]    dx, dy;
  logic [CARRY_W-1:0]  d0;
  logic                seg_skip, dup_c, dup_v, slot_full, fin_emit;
  logic                load_ok, out_last;
  logic [CW-1:0]       slots;

  logic                sq_start, sq_done;
  logic [SQ_OW-1:0]    sq_root;
  logic                div_start, div_done;
  logic [NW-1:0]       div_n;
  logic [DIV_DW-1:0]   div_d;
  logic [DIV_QW-1:0]   div_q;
  logic [DIV_DW-1:0]   div_r;

  logic                mem_we, rd_en, out_load;
  logic [2*COORD_W-1:0] mem_wdata, mem_rdata;

  function automatic logic near(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
    logic signed [COORD_W:0] df;
    df = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return (df <= TOL_S) && (df >= -TOL_S);
  endfunction

  assign dx        = {vx[COORD_W-1], vx} - {prev_x[COORD_W-1], prev_x};
  assign dy        = {vy[COORD_W-1], vy} - {prev_y[COORD_W-1], prev_y};
  assign d0        = (CARRY_W'(sp) > carried) ? CARRY_W'(sp) - carried : '0;
  assign seg_skip  = (len == '0) || (LEN_W'(d0) > len);
  assign dup_c     = near(nx, em_x) && near(ny, em_y);
  assign dup_v     = near(vx, em_x) && near(vy, em_y);
  assign slots     = fin_r ? SLOTS_FIN : SLOTS_ALL;
  assign slot_full = n >= slots;
  assign fin_emit  = fin_r && ((em_cnt == 2'd1) || !dup_v);
  assign load_ok   = !m_axis_tvalid || m_axis_tready;
  assign out_last  = CW'(rd_idx + 1'b1) == n;

  always_comb begin
    mul_a = mag_x;
    mul_b = p[LEN_W-1:0];
    case (state)
      S_SQ1:   mul_b = LEN_W'(mag_x);
      S_SQ2: begin
        mul_a = mag_y;
        mul_b = LEN_W'(mag_y);
      end
      S_MY:    mul_a = mag_y;
      default: mul_a = mag_x;
    endcase
  end

  always_comb begin
    if (state == S_SEG) begin
      div_n = NW'(len - LEN_W'(d0));
      div_d = DIV_DW'(sp);
    end else begin
      div_n = NW'({prod, 1'b0}) + NW'(len);
      div_d = {len, 1'b0};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (s_axis_tuser[0] || (sp == '0)) ? S_EMITV : S_DIFF;
        end
      end
      S_EMITV:  state_next = S_DONE;
      S_DIFF:   state_next = S_SQ1;
      S_SQ1:    state_next = S_SQ2;
      S_SQ2:    state_next = S_SQ3;
      S_SQ3:    state_next = S_SQRT;
      S_SQRT:   if (sq_done) state_next = S_SEG;
      S_SEG:    state_next = seg_skip ? S_FINAL : S_CDIV;
      S_CDIV:   if (div_done) state_next = S_CAND;
      S_CAND:   state_next = (p > PW'(len)) ? S_FINAL : S_MX;
      S_MX:     state_next = S_NX;
      S_NX:     state_next = S_DX;
      S_DX:     if (div_done) state_next = S_MY;
      S_MY:     state_next = S_NY;
      S_NY:     state_next = S_DY;
      S_DY:     if (div_done) state_next = S_CHK;
      S_CHK:    state_next = (!dup_c && slot_full) ? S_FINAL : S_CAND;
      S_FINAL:  state_next = S_DONE;
      S_DONE:   state_next = (n == '0) ? S_IDLE : S_OUT_RD;
      S_OUT_RD: state_next = S_OUT_LD;
      S_OUT_LD: begin
        if (load_ok) begin
          state_next = out_last ? S_IDLE : S_OUT_RD;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    sq_start      = 1'b0;
    div_start     = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = {vy, vx};
    rd_en         = 1'b0;
    out_load      = 1'b0;
    case (state)
      S_IDLE:   s_axis_tready = 1'b1;
      S_EMITV:  mem_we = 1'b1;
      S_SQ3:    sq_start = 1'b1;
      S_SEG:    div_start = !seg_skip;
      S_NX:     div_start = 1'b1;
      S_NY:     div_start = 1'b1;
      S_CHK: begin
        mem_we    = !dup_c && !slot_full;
        mem_wdata = {ny, nx};
      end
      S_FINAL:  mem_we = fin_emit;
      S_OUT_RD: rd_en = 1'b1;
      S_OUT_LD: out_load = load_ok;
      default:  s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sp      <= SPACE_RESET;
      prev_x  <= '0;
      prev_y  <= '0;
      em_x    <= '0;
      em_y    <= '0;
      carried <= '0;
      em_cnt  <= '0;
      n       <= '0;
      clip_r  <= 1'b0;
      rd_idx  <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        sp <= cfg_wr_data;
      end
      prod <= PRODW'(mul_a) * PRODW'(mul_b);
      if (mem_we) begin
        em_x   <= mem_wdata[COORD_W-1:0];
        em_y   <= mem_wdata[2*COORD_W-1:COORD_W];
        n      <= n + 1'b1;
        em_cnt <= (em_cnt == 2'd2) ? 2'd2 : em_cnt + 2'd1;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            vx      <= s_axis_tdata[COORD_W-1:0];
            vy      <= s_axis_tdata[2*COORD_W-1:COORD_W];
            fin_r   <= s_axis_tlast;
            n       <= '0;
            clip_r  <= 1'b0;
            if (s_axis_tuser[0]) begin
              em_cnt  <= '0;
              carried <= '0;
            end else if (sp == '0) begin
              carried <= '0;
            end
          end
        end
        S_DIFF: begin
          sgn_x <= dx[COORD_W];
          sgn_y <= dy[COORD_W];
          mag_x <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
          mag_y <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        end
        S_SQ2:  acc <= prod;
        S_SQRT: if (sq_done) len <= sq_root;
        S_SEG: begin
          if (len != '0) begin
            if (LEN_W'(d0) > len) begin
              carried <= CARRY_W'(carried + len);
            end else begin
              p <= PW'(d0);
            end
          end
        end
        S_CDIV: if (div_done) carried <= div_r[CARRY_W-1:0];
        S_DX: begin
          if (div_done) begin
            nx <= sgn_x ? prev_x - div_q[COORD_W-1:0] : prev_x + div_q[COORD_W-1:0];
          end
        end
        S_DY: begin
          if (div_done) begin
            ny <= sgn_y ? prev_y - div_q[COORD_W-1:0] : prev_y + div_q[COORD_W-1:0];
          end
        end
        S_CHK: begin
          if (!dup_c && slot_full) begin
            clip_r <= 1'b1;
          end else begin
            p <= p + PW'(sp);
          end
        end
        S_DONE: begin
          prev_x <= vx;
          prev_y <= vy;
          rd_idx <= '0;
        end
        S_OUT_LD: if (load_ok) rd_idx <= rd_idx + 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= mem_rdata;
      m_axis_tlast <= out_last;
      m_axis_tuser <= {clip_r, out_last && fin_r};
    end
  end

  pur_sqrt #(
    .OW (SQ_OW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand ((2*SQ_OW)'(acc + prod)),
    .root     (sq_root),
    .done     (sq_done)
  );

  pur_div #(
    .QW (DIV_QW),
    .DW (DIV_DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .quotient  (div_q),
    .remainder (div_r),
    .done      (div_done)
  );

  pur_rbuf #(
    .DEPTH (MAX_OUT),
    .AW    (AW),
    .DW    (2*COORD_W)
  ) u_rbuf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (n[AW-1:0]),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_idx[AW-1:0]),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== sv/pur_checker.sv =====
// ----------------------------------------------------------------------------
// Polyline resampler port checker
// Watches the stream ports of the resampler over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyline_uniform_resampler_defines.svh"

module pur_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [2*pur_pkg::COORD_W-1:0] m_axis_tdata,
  input logic [1:0]                    m_axis_tuser,
  input logic                          m_axis_tlast
);

  logic out_stall;

  assign out_stall = m_axis_tvalid && !m_axis_tready;

  `PUR_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "word moved in stall")
  `PUR_ASSERT_IMP(a_poly_end_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "end w/o tlast")
  `PUR_ASSERT_IMP(a_idle_tail, s_axis_tready && m_axis_tvalid, m_axis_tlast, "input taken early")
  `PUR_ASSERT_IMP(a_reset_empty, $past(rst), !m_axis_tvalid, "output valid right after reset")

endmodule

bind polyline_uniform_resampler pur_checker u_pur_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
